>>> rtl/sts_pkg.sv
// Shared types, constants and slot tables of the sphere triangle subdivider.
package sts_pkg;

	localparam int CoordW   = 16;
	localparam int FracBits = 14;
	localparam int MaxDepth = 3;
	localparam int SumW     = CoordW + 1;
	localparam int SqW      = 2 * SumW;
	localparam int LenW     = SqW + 1;
	localparam int LenLoW   = 18;
	localparam int LenHiW   = LenW - LenLoW;
	localparam int QW       = FracBits + 1;
	localparam int TW       = QW + 1;
	localparam int T2W      = 2 * QW;
	localparam int RhsW     = SqW + 2 * FracBits + 2;
	localparam int LhsW     = T2W + LenW + 1;
	localparam int BitW     = $clog2(FracBits + 1);
	localparam int LevelW   = 2;
	localparam int SlotW    = 3;
	localparam int AddrW    = LevelW + SlotW;
	localparam int MemDepth = 1 << AddrW;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
	} vtx_t;

	typedef enum logic [1:0] {
		WS_TRI,
		WS_NORM,
		WS_RDATA
	} wsrc_t;

	typedef struct packed {
		logic             load_in;
		logic             rd_en;
		logic [AddrW-1:0] rd_addr;
		logic             wr_en;
		logic [AddrW-1:0] wr_addr;
		wsrc_t            wr_src;
		logic [1:0]       vidx;
		logic             cap_a;
		logic             norm_start;
		logic             stage_en;
		logic             push;
		logic             push_last;
	} dp_cmd_t;

	typedef struct packed {
		logic norm_done;
		logic out_busy;
	} dp_sts_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_LOAD,
		C_VISIT,
		C_MID_A,
		C_MID_B,
		C_MID_S,
		C_MID_W,
		C_CP_R,
		C_CP_W,
		C_EMIT_R,
		C_EMIT_W,
		C_PUSH,
		C_UP
	} ctrl_state_t;

	typedef enum logic [3:0] {
		N_IDLE,
		N_SQ,
		N_ZCHK,
		N_MAG,
		N_TSQ,
		N_PART,
		N_CMP,
		N_FIN,
		N_DONE
	} norm_state_t;

	// Slots of one level: corners 0..2, edge points m12, m23, m31 at 3..5
	localparam logic [SlotW-1:0] SlotV1  = 3'd0;
	localparam logic [SlotW-1:0] SlotV2  = 3'd1;
	localparam logic [SlotW-1:0] SlotV3  = 3'd2;
	localparam logic [SlotW-1:0] SlotM12 = 3'd3;
	localparam logic [SlotW-1:0] SlotM23 = 3'd4;
	localparam logic [SlotW-1:0] SlotM31 = 3'd5;

	function automatic logic [AddrW-1:0] mem_addr(input logic [LevelW-1:0] lv,
		input logic [SlotW-1:0] slot);
		return {lv, slot};
	endfunction

	// First and second end point of edge e
	function automatic logic [SlotW-1:0] edge_slot(input logic [1:0] e, input logic second);
		logic [SlotW-1:0] s;
		case (e)
			2'd0:    s = second ? SlotV2 : SlotV1;
			2'd1:    s = second ? SlotV3 : SlotV2;
			default: s = second ? SlotV1 : SlotV3;
		endcase
		return s;
	endfunction

	function automatic logic [SlotW-1:0] mid_slot(input logic [1:0] e);
		logic [SlotW-1:0] s;
		case (e)
			2'd0:    s = SlotM12;
			2'd1:    s = SlotM23;
			default: s = SlotM31;
		endcase
		return s;
	endfunction

	// Corner k of child c
	function automatic logic [SlotW-1:0] child_slot(input logic [1:0] c, input logic [1:0] k);
		logic [SlotW-1:0] s;
		case ({c, k})
			4'b00_00: s = SlotV1;
			4'b00_01: s = SlotM12;
			4'b00_10: s = SlotM31;
			4'b01_00: s = SlotV2;
			4'b01_01: s = SlotM23;
			4'b01_10: s = SlotM12;
			4'b10_00: s = SlotV3;
			4'b10_01: s = SlotM31;
			4'b10_10: s = SlotM23;
			4'b11_00: s = SlotM12;
			4'b11_01: s = SlotM23;
			4'b11_10: s = SlotM31;
			default:  s = SlotV1;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/sts_tri_if.sv
// Input channel: one triangle of three vertices.
interface sts_tri_if;
	logic                             valid;
	logic                             ready;
	logic signed [sts_pkg::CoordW-1:0] a_x, a_y, a_z;
	logic signed [sts_pkg::CoordW-1:0] b_x, b_y, b_z;
	logic signed [sts_pkg::CoordW-1:0] c_x, c_y, c_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

>>> rtl/sts_res_if.sv
// Result channel: one emitted triangle.
interface sts_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [sts_pkg::CoordW-1:0] p_x, p_y, p_z;
	logic signed [sts_pkg::CoordW-1:0] q_x, q_y, q_z;
	logic signed [sts_pkg::CoordW-1:0] r_x, r_y, r_z;
	logic                             last_triangle;

	modport source (output valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
		last_triangle, input ready);
	modport sink (input valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
		last_triangle, output ready);
endinterface

>>> rtl/sts_cfg_if.sv
// Configuration write channel for the subdivision depth.
interface sts_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] subdivision_depth;

	modport source (output valid, subdivision_depth, input ready);
	modport sink (input valid, subdivision_depth, output ready);
endinterface

>>> rtl/sts_norm.sv
// Iterative normalizer: projects an edge sum onto the unit sphere, one result bit per step.
module sts_norm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [sts_pkg::SumW-1:0]  sum_x,
	input  logic signed [sts_pkg::SumW-1:0]  sum_y,
	input  logic signed [sts_pkg::SumW-1:0]  sum_z,
	output logic                             done,
	output sts_pkg::vtx_t                    res
);

	sts_pkg::norm_state_t state_q, state_d;

	logic signed [sts_pkg::SumW-1:0]   s_q [3];
	logic        [1:0]                 idx_q;
	logic        [sts_pkg::LenW-1:0]   len_q;
	logic        [sts_pkg::RhsW-1:0]   rhs_q;
	logic        [sts_pkg::QW-1:0]     q_q;
	logic        [sts_pkg::BitW-1:0]   bit_q;
	logic        [sts_pkg::T2W-1:0]    t2_q;
	logic        [sts_pkg::LenLoW+sts_pkg::T2W-1:0] pl_q;
	logic        [sts_pkg::LenHiW+sts_pkg::T2W-1:0] ph_q;
	logic signed [sts_pkg::CoordW-1:0] res_q [3];

	logic [sts_pkg::SumW-1:0] mag;
	logic [sts_pkg::SqW-1:0]  sq;
	logic [sts_pkg::QW-1:0]   cand;
	logic [sts_pkg::TW-1:0]   t;
	logic [2*sts_pkg::TW-1:0] t_sq;
	logic [sts_pkg::LhsW-1:0] lhs;
	logic                     fit;
	logic                     skip;
	logic [sts_pkg::CoordW-1:0] qpos;

	// Magnitude and square of the selected coordinate
	assign mag  = s_q[idx_q][sts_pkg::SumW-1] ? (~s_q[idx_q] + 1'b1) : s_q[idx_q];
	assign sq   = mag * mag;

	// Trial bit and the squared midpoint of its rounding interval
	assign cand = q_q | (sts_pkg::QW'(1) << bit_q);
	assign t    = {cand, 1'b0} - sts_pkg::TW'(1);
	assign t_sq = t * t;
	assign skip = q_q[sts_pkg::QW-1];

	assign lhs  = {1'b0, ph_q, {sts_pkg::LenLoW{1'b0}}}
		+ sts_pkg::LhsW'(pl_q);
	assign fit  = lhs <= sts_pkg::LhsW'(rhs_q);
	assign qpos = sts_pkg::CoordW'(q_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sts_pkg::N_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sts_pkg::N_IDLE: if (start) state_d = sts_pkg::N_SQ;
			sts_pkg::N_SQ:   if (idx_q == 2'd2) state_d = sts_pkg::N_ZCHK;
			sts_pkg::N_ZCHK: state_d = (len_q == '0) ? sts_pkg::N_DONE : sts_pkg::N_MAG;
			sts_pkg::N_MAG:  state_d = sts_pkg::N_TSQ;
			sts_pkg::N_TSQ:  state_d = skip ? sts_pkg::N_FIN : sts_pkg::N_PART;
			sts_pkg::N_PART: state_d = sts_pkg::N_CMP;
			sts_pkg::N_CMP:  state_d = (bit_q == '0) ? sts_pkg::N_FIN : sts_pkg::N_TSQ;
			sts_pkg::N_FIN:  state_d = (idx_q == 2'd2) ? sts_pkg::N_DONE : sts_pkg::N_MAG;
			sts_pkg::N_DONE: state_d = sts_pkg::N_IDLE;
			default:         state_d = sts_pkg::N_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			sts_pkg::N_IDLE: begin
				if (start) begin
					s_q[0] <= sum_x;
					s_q[1] <= sum_y;
					s_q[2] <= sum_z;
					idx_q  <= 2'd0;
					len_q  <= '0;
				end
			end
			sts_pkg::N_SQ: begin
				len_q <= len_q + sts_pkg::LenW'(sq);
				idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
			end
			sts_pkg::N_ZCHK: begin
				// zero-length sum maps to the x axis
				res_q[0] <= sts_pkg::CoordW'(1) << sts_pkg::FracBits;
				res_q[1] <= '0;
				res_q[2] <= '0;
			end
			sts_pkg::N_MAG: begin
				rhs_q <= {sq, {(2 * sts_pkg::FracBits + 2){1'b0}}};
				q_q   <= '0;
				bit_q <= sts_pkg::BitW'(sts_pkg::FracBits);
			end
			sts_pkg::N_TSQ: begin
				t2_q <= t_sq[sts_pkg::T2W-1:0];
			end
			sts_pkg::N_PART: begin
				pl_q <= t2_q * len_q[sts_pkg::LenLoW-1:0];
				ph_q <= t2_q * len_q[sts_pkg::LenW-1:sts_pkg::LenLoW];
			end
			sts_pkg::N_CMP: begin
				if (fit) q_q <= cand;
				bit_q <= bit_q - sts_pkg::BitW'(1);
			end
			sts_pkg::N_FIN: begin
				res_q[idx_q] <= s_q[idx_q][sts_pkg::SumW-1] ? -qpos : qpos;
				idx_q        <= idx_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == sts_pkg::N_DONE);
	assign res  = '{x: res_q[0], y: res_q[1], z: res_q[2]};

endmodule

>>> rtl/sts_datapath.sv
// Datapath: vertex store, edge sums, normalizer, staging and result register.
module sts_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  sts_pkg::dp_cmd_t cmd,
	output sts_pkg::dp_sts_t sts,
	input  sts_pkg::vtx_t    in_a,
	input  sts_pkg::vtx_t    in_b,
	input  sts_pkg::vtx_t    in_c,
	output sts_pkg::vtx_t    out_p,
	output sts_pkg::vtx_t    out_q,
	output sts_pkg::vtx_t    out_r,
	output logic             out_last,
	output logic             out_valid,
	input  logic             out_ready
);

	sts_pkg::vtx_t tri_q [3];
	sts_pkg::vtx_t mem [sts_pkg::MemDepth];
	sts_pkg::vtx_t rdata_q;
	sts_pkg::vtx_t hold_q;
	sts_pkg::vtx_t stg_q [3];
	sts_pkg::vtx_t res_q [3];
	logic          last_q;
	logic          valid_q;

	sts_pkg::vtx_t wdata;
	sts_pkg::vtx_t norm_res;
	logic          norm_done;
	logic signed [sts_pkg::SumW-1:0] sum_x, sum_y, sum_z;

	// Edge sum of the held end point and the one just read
	assign sum_x = {hold_q.x[sts_pkg::CoordW-1], hold_q.x}
		+ {rdata_q.x[sts_pkg::CoordW-1], rdata_q.x};
	assign sum_y = {hold_q.y[sts_pkg::CoordW-1], hold_q.y}
		+ {rdata_q.y[sts_pkg::CoordW-1], rdata_q.y};
	assign sum_z = {hold_q.z[sts_pkg::CoordW-1], hold_q.z}
		+ {rdata_q.z[sts_pkg::CoordW-1], rdata_q.z};

	sts_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.norm_start),
		.sum_x  (sum_x),
		.sum_y  (sum_y),
		.sum_z  (sum_z),
		.done   (norm_done),
		.res    (norm_res)
	);

	// Store write data
	always_comb begin
		case (cmd.wr_src)
			sts_pkg::WS_TRI:   wdata = tri_q[cmd.vidx];
			sts_pkg::WS_NORM:  wdata = norm_res;
			sts_pkg::WS_RDATA: wdata = rdata_q;
			default:           wdata = rdata_q;
		endcase
	end

	// Vertex store with registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[cmd.wr_addr] <= wdata;
		if (cmd.rd_en) rdata_q <= mem[cmd.rd_addr];
	end

	// Input capture, edge hold and staging
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			tri_q[0] <= in_a;
			tri_q[1] <= in_b;
			tri_q[2] <= in_c;
		end
		if (cmd.cap_a) hold_q <= rdata_q;
		if (cmd.stage_en) stg_q[cmd.vidx] <= rdata_q;
		if (cmd.push) begin
			res_q[0] <= stg_q[0];
			res_q[1] <= stg_q[1];
			res_q[2] <= stg_q[2];
			last_q   <= cmd.push_last;
		end
	end

	// Result valid: set on push, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign sts.norm_done = norm_done;
	assign sts.out_busy  = valid_q & ~out_ready;

	assign out_p     = res_q[0];
	assign out_q     = res_q[1];
	assign out_r     = res_q[2];
	assign out_last  = last_q;
	assign out_valid = valid_q;

endmodule

>>> rtl/sts_ctrl.sv
// Controller: depth-first walk over the split tree, sequencing the datapath.
module sts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_depth,
	input  sts_pkg::dp_sts_t sts,
	output sts_pkg::dp_cmd_t cmd
);

	sts_pkg::ctrl_state_t state_q, state_d;

	logic [1:0]                 depth_q;
	logic [sts_pkg::LevelW-1:0] dep_q;
	logic [sts_pkg::LevelW-1:0] lv_q;
	logic [1:0]                 e_q;
	logic [1:0]                 k_q;
	logic [1:0]                 child_q [sts_pkg::MaxDepth+1];

	logic [sts_pkg::LevelW-1:0] eff_depth;
	logic                       last;
	logic                       in_xfer;

	assign eff_depth = (depth_q > 2'(sts_pkg::MaxDepth)) ? 2'(sts_pkg::MaxDepth) : depth_q;
	assign in_ready  = (state_q == sts_pkg::C_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid & in_ready;

	// Final leaf: every active level is on its last child
	always_comb begin
		last = 1'b1;
		for (int l = 1; l <= sts_pkg::MaxDepth; l++) begin
			if (l <= int'(dep_q) && child_q[l] != 2'd3) last = 1'b0;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sts_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			sts_pkg::C_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = sts_pkg::C_LOAD;
				end
			end
			sts_pkg::C_LOAD: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = sts_pkg::mem_addr(lv_q, sts_pkg::SlotW'(k_q));
				cmd.wr_src  = sts_pkg::WS_TRI;
				cmd.vidx    = k_q;
				if (k_q == 2'd2) state_d = sts_pkg::C_VISIT;
			end
			sts_pkg::C_VISIT: begin
				state_d = (lv_q == '0) ? sts_pkg::C_EMIT_R : sts_pkg::C_MID_A;
			end
			sts_pkg::C_MID_A: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = sts_pkg::mem_addr(lv_q, sts_pkg::edge_slot(e_q, 1'b0));
				state_d     = sts_pkg::C_MID_B;
			end
			sts_pkg::C_MID_B: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = sts_pkg::mem_addr(lv_q, sts_pkg::edge_slot(e_q, 1'b1));
				cmd.cap_a   = 1'b1;
				state_d     = sts_pkg::C_MID_S;
			end
			sts_pkg::C_MID_S: begin
				cmd.norm_start = 1'b1;
				state_d        = sts_pkg::C_MID_W;
			end
			sts_pkg::C_MID_W: begin
				if (sts.norm_done) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = sts_pkg::mem_addr(lv_q, sts_pkg::mid_slot(e_q));
					cmd.wr_src  = sts_pkg::WS_NORM;
					state_d     = (e_q == 2'd2) ? sts_pkg::C_CP_R : sts_pkg::C_MID_A;
				end
			end
			sts_pkg::C_CP_R: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = sts_pkg::mem_addr(lv_q, sts_pkg::child_slot(child_q[lv_q], k_q));
				state_d     = sts_pkg::C_CP_W;
			end
			sts_pkg::C_CP_W: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = sts_pkg::mem_addr(lv_q - 1'b1, sts_pkg::SlotW'(k_q));
				cmd.wr_src  = sts_pkg::WS_RDATA;
				state_d     = (k_q == 2'd2) ? sts_pkg::C_VISIT : sts_pkg::C_CP_R;
			end
			sts_pkg::C_EMIT_R: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = sts_pkg::mem_addr('0, sts_pkg::SlotW'(k_q));
				state_d     = sts_pkg::C_EMIT_W;
			end
			sts_pkg::C_EMIT_W: begin
				cmd.stage_en = 1'b1;
				cmd.vidx     = k_q;
				state_d      = (k_q == 2'd2) ? sts_pkg::C_PUSH : sts_pkg::C_EMIT_R;
			end
			sts_pkg::C_PUSH: begin
				if (!sts.out_busy) begin
					cmd.push      = 1'b1;
					cmd.push_last = last;
					state_d       = last ? sts_pkg::C_IDLE : sts_pkg::C_UP;
				end
			end
			sts_pkg::C_UP: begin
				if (child_q[lv_q] != 2'd3) state_d = sts_pkg::C_CP_R;
			end
			default: state_d = sts_pkg::C_IDLE;
		endcase
	end

	// Depth register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cfg_valid) begin
			depth_q <= cfg_depth;
		end
	end

	// Walk position: level, edge, corner and child counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_q <= '0;
			lv_q  <= '0;
			e_q   <= '0;
			k_q   <= '0;
			for (int l = 0; l <= sts_pkg::MaxDepth; l++) child_q[l] <= '0;
		end else begin
			case (state_q)
				sts_pkg::C_IDLE: begin
					if (in_xfer) begin
						dep_q <= eff_depth;
						lv_q  <= eff_depth;
						k_q   <= '0;
					end
				end
				sts_pkg::C_LOAD: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				sts_pkg::C_VISIT: begin
					e_q <= '0;
					k_q <= '0;
				end
				sts_pkg::C_MID_W: begin
					if (sts.norm_done) begin
						e_q <= e_q + 2'd1;
						if (e_q == 2'd2) begin
							child_q[lv_q] <= '0;
							k_q           <= '0;
						end
					end
				end
				sts_pkg::C_CP_W: begin
					if (k_q == 2'd2) begin
						k_q  <= '0;
						lv_q <= lv_q - 1'b1;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				sts_pkg::C_EMIT_W: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				sts_pkg::C_PUSH: begin
					if (!sts.out_busy) lv_q <= sts_pkg::LevelW'(1);
				end
				sts_pkg::C_UP: begin
					// climb past finished levels, else advance to the next child
					if (child_q[lv_q] == 2'd3) begin
						lv_q <= lv_q + 1'b1;
					end else begin
						child_q[lv_q] <= child_q[lv_q] + 2'd1;
						k_q           <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/sphere_triangle_subdivider.sv
// Top level of the sphere triangle subdivider.
// Takes one triangle of unit-sphere vertices (signed Q1.14) per input transfer and returns
// 4^depth triangles in depth-first order, the last one flagged by last_triangle; depth 0
// returns the input unchanged. One triangle is worked on at a time: the input is not ready
// again until the last result has been handed to the output register. Each edge point is
// made by one shared iterative normalizer (three squares, then three passes, one per
// coordinate, that find the result one bit per step). The depth register may be written
// at any time through its channel and takes effect with the next input triangle.
module sphere_triangle_subdivider (
	input  logic       clk,
	input  logic       arst_n,
	sts_tri_if.sink    tri_in,
	sts_res_if.source  tri_out,
	sts_cfg_if.sink    cfg
);

	sts_pkg::dp_cmd_t cmd;
	sts_pkg::dp_sts_t sts;
	sts_pkg::vtx_t    in_a, in_b, in_c;
	sts_pkg::vtx_t    out_p, out_q, out_r;

	assign in_a = '{x: tri_in.a_x, y: tri_in.a_y, z: tri_in.a_z};
	assign in_b = '{x: tri_in.b_x, y: tri_in.b_y, z: tri_in.b_z};
	assign in_c = '{x: tri_in.c_x, y: tri_in.c_y, z: tri_in.c_z};

	sts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tri_in.valid),
		.in_ready  (tri_in.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cfg_depth (cfg.subdivision_depth),
		.sts       (sts),
		.cmd       (cmd)
	);

	sts_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_a      (in_a),
		.in_b      (in_b),
		.in_c      (in_c),
		.out_p     (out_p),
		.out_q     (out_q),
		.out_r     (out_r),
		.out_last  (tri_out.last_triangle),
		.out_valid (tri_out.valid),
		.out_ready (tri_out.ready)
	);

	// Unpack result vertices onto the channel
	assign tri_out.p_x = out_p.x;
	assign tri_out.p_y = out_p.y;
	assign tri_out.p_z = out_p.z;
	assign tri_out.q_x = out_q.x;
	assign tri_out.q_y = out_q.y;
	assign tri_out.q_z = out_q.z;
	assign tri_out.r_x = out_r.x;
	assign tri_out.r_y = out_r.y;
	assign tri_out.r_z = out_r.z;

endmodule

>>> rtl/sts_checker.sv
// Port-level checks of the sphere triangle subdivider, bound to the top level.
module sts_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic         out_last,
	input logic [144:0] out_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Drop input ready once a triangle is taken
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a triangle is in work");

	// Stay busy while a result that is not the last is waiting
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input ready before the last triangle");

endmodule

bind sphere_triangle_subdivider sts_checker u_sts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (tri_in.valid),
	.in_ready  (tri_in.ready),
	.out_valid (tri_out.valid),
	.out_ready (tri_out.ready),
	.out_last  (tri_out.last_triangle),
	.out_data  ({tri_out.p_x, tri_out.p_y, tri_out.p_z, tri_out.q_x, tri_out.q_y,
		tri_out.q_z, tri_out.r_x, tri_out.r_y, tri_out.r_z, tri_out.last_triangle})
);

>>> verif/sts_tb_pkg.sv
`timescale 1ns / 100ps
// Expected-triangle predictor for the sphere triangle subdivider.
package sts_tb_pkg;
	import sts_pkg::*;

	typedef struct packed {
		logic signed [CoordW-1:0] px, py, pz, qx, qy, qz, rx, ry, rz;
		logic                     last;
	} tri_res_t;

	typedef struct {
		longint c[3];
	} pt_t;

	// Project one summed coordinate onto the sphere, rounding half away from zero
	function automatic longint sphere_coord(longint s, longint len2);
		longint m, q, cand, t;
		logic [127:0] rhs, lhs;
		m = (s < 0) ? -s : s;
		q = 0;
		rhs = 128'(4 * m * m) << (2 * FracBits);
		for (int b = FracBits; b >= 0; b--) begin
			cand = q | (longint'(1) << b);
			if (cand > (longint'(1) << FracBits))
				continue;
			t = 2 * cand - 1;
			lhs = 128'(t * t) * 128'(len2);
			if (lhs <= rhs)
				q = cand;
		end
		if (s < 0)
			q = -q;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q;
	endfunction

	function automatic pt_t edge_mid(pt_t u, pt_t v);
		pt_t r;
		longint s[3];
		longint len2;
		len2 = 0;
		for (int i = 0; i < 3; i++) begin
			s[i] = u.c[i] + v.c[i];
			len2 += s[i] * s[i];
		end
		if (len2 == 0) begin
			r.c[0] = longint'(1) << FracBits;
			r.c[1] = 0;
			r.c[2] = 0;
		end else begin
			for (int i = 0; i < 3; i++)
				r.c[i] = sphere_coord(s[i], len2);
		end
		return r;
	endfunction

	// Depth-first split, leaves appended to the queue
	function automatic void split_tri(pt_t v1, pt_t v2, pt_t v3, int lvl,
		ref tri_res_t leaves[$]);
		pt_t m12, m23, m31;
		tri_res_t t;
		if (lvl == 0) begin
			t.px = CoordW'(v1.c[0]); t.py = CoordW'(v1.c[1]); t.pz = CoordW'(v1.c[2]);
			t.qx = CoordW'(v2.c[0]); t.qy = CoordW'(v2.c[1]); t.qz = CoordW'(v2.c[2]);
			t.rx = CoordW'(v3.c[0]); t.ry = CoordW'(v3.c[1]); t.rz = CoordW'(v3.c[2]);
			t.last = 1'b0;
			leaves.push_back(t);
		end else begin
			m12 = edge_mid(v1, v2);
			m23 = edge_mid(v2, v3);
			m31 = edge_mid(v3, v1);
			split_tri(v1, m12, m31, lvl - 1, leaves);
			split_tri(v2, m23, m12, lvl - 1, leaves);
			split_tri(v3, m31, m23, lvl - 1, leaves);
			split_tri(m12, m23, m31, lvl - 1, leaves);
		end
	endfunction
endpackage

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the sphere triangle subdivider.
module tb;
	import sts_pkg::*;
	import sts_tb_pkg::*;

	typedef logic signed [CoordW-1:0] crd_t;
	typedef struct {
		int v[9];
		logic has_exp;
		tri_res_t exp_tri;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	sts_tri_if tri_ch();
	sts_res_if res_ch();
	sts_cfg_if cfg_ch();

	sphere_triangle_subdivider uut (
		.clk(clk), .arst_n(arst_n), .tri_in(tri_ch.sink), .tri_out(res_ch.source), .cfg(cfg_ch.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tri_res_t expected_tris[$];
	int errors = 0;
	logic [1:0] depth_now = 2'd0;
	logic calm = 1'b0;
	int sink_hold = 0;

	initial begin
		tri_ch.valid = 1'b0;
		{tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y, tri_ch.b_z,
			tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.subdivision_depth = 2'd0;
		res_ch.ready = 1'b0;
	end

	// Randomly stall the result side in bursts
	always @(posedge clk) begin
		if (calm) begin
			res_ch.ready <= 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			res_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			sink_hold <= $urandom_range(0, 16);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest expected triangle
	always @(posedge clk) begin
		tri_res_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.p_x, res_ch.p_y, res_ch.p_z, res_ch.q_x, res_ch.q_y, res_ch.q_z,
				res_ch.r_x, res_ch.r_y, res_ch.r_z, res_ch.last_triangle};
			if (expected_tris.size() == 0) begin
				$display("%0t unexpected triangle %h", $time, got);
				errors++;
			end else begin
				want = expected_tris.pop_front();
				if (got !== want) begin
					$display("%0t mismatch expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	task automatic write_depth(input logic [1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.subdivision_depth <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		depth_now = d;
	endtask

	// Drop the input and hold until every expected triangle has come
	task automatic wait_empty();
		tri_ch.valid <= 1'b0;
		while (expected_tris.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		wait_empty();
		repeat (20) @(posedge clk);
	endtask

	// Queue the predicted triangles, then offer the triangle until it transfers
	task automatic send_tri(input int v[9], input logic has_exp, input tri_res_t exp_tri);
		pt_t p[3];
		tri_res_t leaves[$];
		crd_t c[9];
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			tri_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		foreach (v[k])
			c[k] = crd_t'(v[k]);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				p[i].c[j] = longint'(c[i * 3 + j]);
		split_tri(p[0], p[1], p[2], int'(depth_now), leaves);
		leaves[leaves.size() - 1].last = 1'b1;
		if (has_exp && leaves[0] !== exp_tri) begin
			$display("%0t mismatch expected %h actual %h", $time, exp_tri, leaves[0]);
			errors++;
		end
		foreach (leaves[k])
			expected_tris.push_back(leaves[k]);
		tri_ch.valid <= 1'b1;
		{tri_ch.a_x, tri_ch.a_y, tri_ch.a_z} <= {c[0], c[1], c[2]};
		{tri_ch.b_x, tri_ch.b_y, tri_ch.b_z} <= {c[3], c[4], c[5]};
		{tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} <= {c[6], c[7], c[8]};
		do @(posedge clk); while (!tri_ch.ready);
	endtask

	function automatic crd_t rand_coord();
		case ($urandom_range(0, 5))
			0: return crd_t'($urandom);
			1: return crd_t'(16384);
			2: return crd_t'(-16384);
			default: return crd_t'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		int v[9];
		tri_res_t none;
		none = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Depth 0 after reset: triangle passes through unchanged
		r.v = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
		r.has_exp = 1'b1;
		r.exp_tri = {16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
			16'sd0, 16'sd0, 16'sd16384, 1'b1};
		rows.push_back(r);
		r.v = '{-32768, 32767, -1, 0, -32768, 32767, 1, -1, 0};
		r.exp_tri = {-16'sd32768, 16'sd32767, -16'sd1, 16'sd0, -16'sd32768, 16'sd32767,
			16'sd1, -16'sd1, 16'sd0, 1'b1};
		rows.push_back(r);
		foreach (rows[i])
			send_tri(rows[i].v, rows[i].has_exp, rows[i].exp_tri);
		wait_drained();

		// Split cases: unit axes, opposite vertices (zero-length sums), extremes
		rows.delete();
		r.has_exp = 1'b0;
		r.v = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; rows.push_back(r);
		r.v = '{16384, 0, 0, -16384, 0, 0, 0, 16384, 0}; rows.push_back(r);
		r.v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; rows.push_back(r);
		r.v = '{-32768, -32768, -32768, 32767, 32767, 32767, -1, 1, 0}; rows.push_back(r);
		r.v = '{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768};
		rows.push_back(r);
		r.v = '{1, 0, 0, 0, 1, 0, 0, 0, -1}; rows.push_back(r);
		r.v = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; rows.push_back(r);
		write_depth(2'd1);
		foreach (rows[i])
			send_tri(rows[i].v, 1'b0, none);
		wait_drained();
		write_depth(2'd3);
		send_tri(rows[0].v, 1'b0, none);
		send_tri(rows[1].v, 1'b0, none);
		wait_drained();
		write_depth(2'd2);
		foreach (rows[i])
			send_tri(rows[i].v, 1'b0, none);
		wait_drained();

		// Random triangles over several depths, mostly shallow
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_depth(2'd0);
				1: write_depth(2'd1);
				2: write_depth(2'd2);
				3: write_depth(2'd1);
				4: write_depth(2'd3);
				default: write_depth(2'd0);
			endcase
			if (ph == 5)
				calm = 1'b1;
			for (int n = 0; n < ((ph == 4) ? 6 : (ph == 2 ? 30 : 65)); n++) begin
				foreach (v[k])
					v[k] = int'(rand_coord());
				send_tri(v, 1'b0, none);
				// Hold off until everything expected has come back
				if (n == 10)
					wait_empty();
			end
			wait_drained();
		end
		if (errors == 0)
			$display("sphere_triangle_subdivider verification clean");
		else
			$display("sphere_triangle_subdivider verification failed");
		$finish;
	end

	initial begin
		#40ms;
		$display("sphere_triangle_subdivider verification failed");
		$finish;
	end
endmodule
